// File: sv/cwmf_pkg.sv
// Shared constants, types and helpers of the column window max filter.
package cwmf_pkg;

	// Configuration port shape and register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_BEFORE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_AFTER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LENGTH = 2'd2;

	// Register field widths and reset values
	localparam int RADIUS_CFG_W = 5;
	localparam int LENGTH_CFG_W = 13;
	localparam logic [RADIUS_CFG_W-1:0] RADIUS_RESET = 5'd1;
	localparam logic [LENGTH_CFG_W-1:0] LENGTH_RESET = 13'd1024;

	// Most results one sample may release
	localparam int RUN_MAX = 32;
	localparam int RUN_W   = 6;

	// Entries of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Control part of one job
	typedef struct packed {
		logic [RUN_W-1:0] count;   // results to produce
		logic             ending;  // sample closes its column
	} job_ctl_t;

	// Saturate a value at a limit
	function automatic logic [31:0] clamp_to(input logic [31:0] value, input logic [31:0] limit);
		clamp_to = (value > limit) ? limit : value;
	endfunction

endpackage

// File: sv/cwmf_stream_if.sv
// Valid/ready stream interfaces for samples and results.
interface cwmf_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface cwmf_out_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int ROW_W       = 12
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;
	logic        [ROW_W-1:0]       out_row;
	logic                          column_end;
	logic                          run_last;

	modport source (output valid, output window_max, output out_row, output column_end,
		output run_last, input ready);
	modport sink (input valid, input window_max, input out_row, input column_end,
		input run_last, output ready);
endinterface

// File: sv/cwmf_queue.sv
// Small first-in first-out job queue between front and back.
module cwmf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PTR_W = $clog2(cwmf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [W-1:0]     slot_q [cwmf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == CNT_W'(cwmf_pkg::QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/cwmf_front.sv
// Front end: accepts samples, tracks rows and works out the results each sample releases.
module cwmf_front #(
	parameter int SAMPLE_BITS = 16,
	parameter int ROW_W       = 12,
	parameter int RAD_W       = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cwmf_in_if.sink                       pixels,
	input  logic [RAD_W-1:0]              radius_after,
	input  logic [ROW_W-1:0]              last_row,
	input  logic                          queue_full,
	output logic                          push,
	output logic signed [SAMPLE_BITS-1:0] job_sample,
	output logic [ROW_W-1:0]              job_row,
	output logic [ROW_W-1:0]              job_first,
	output cwmf_pkg::job_ctl_t            job_ctl
);
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] next_out_q;
	logic             ending;
	logic             due;
	logic [ROW_W-1:0] upto;
	logic             has_rows;
	logic [31:0]      span;
	logic [cwmf_pkg::RUN_W-1:0] count;

	assign pixels.ready = !queue_full;
	assign push         = pixels.valid && pixels.ready;

	// Classify the sample: how many pending rows become due
	always_comb begin
		ending   = (row_q >= last_row);
		due      = ending || (32'(row_q) >= 32'(radius_after));
		upto     = ending ? row_q : ROW_W'(32'(row_q) - 32'(radius_after));
		has_rows = due && (next_out_q <= upto);
		span     = 32'(upto) - 32'(next_out_q);
		if (!has_rows) begin
			count = '0;
		end else if (span >= 32'(cwmf_pkg::RUN_MAX - 1)) begin
			count = cwmf_pkg::RUN_W'(cwmf_pkg::RUN_MAX);
		end else begin
			count = cwmf_pkg::RUN_W'(span + 32'd1);
		end
	end

	assign job_sample     = pixels.sample;
	assign job_row        = row_q;
	assign job_first      = next_out_q;
	assign job_ctl.count  = count;
	assign job_ctl.ending = ending;

	// Advance row counter and first pending row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			next_out_q <= '0;
		end else if (push) begin
			if (ending) begin
				row_q      <= '0;
				next_out_q <= '0;
			end else begin
				row_q      <= row_q + 1'b1;
				next_out_q <= next_out_q + ROW_W'(count);
			end
		end
	end

endmodule

// File: sv/cwmf_back.sv
// Back end: stores samples and scans each window through the sample memory.
module cwmf_back #(
	parameter int SAMPLE_BITS = 16,
	parameter int ROW_W       = 12,
	parameter int RAD_W       = 5,
	parameter int AW          = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          queue_empty,
	output logic                          pop,
	input  logic signed [SAMPLE_BITS-1:0] job_sample,
	input  logic [ROW_W-1:0]              job_row,
	input  logic [ROW_W-1:0]              job_first,
	input  cwmf_pkg::job_ctl_t            job_ctl,
	input  logic [RAD_W-1:0]              radius_before,
	input  logic [RAD_W-1:0]              radius_after,
	cwmf_out_if.source                    results
);
	localparam int DEPTH = 1 << AW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic signed [SAMPLE_BITS-1:0] store_mem [DEPTH];

	logic [2:0]                 state_q;
	logic [ROW_W-1:0]           cur_q;
	logic [ROW_W-1:0]           row_q;
	logic [cwmf_pkg::RUN_W-1:0] left_q;
	logic                       ending_q;
	logic [ROW_W-1:0]           idx_q;
	logic [ROW_W-1:0]           end_q;
	logic                       first_q;

	logic                          vld_s1;
	logic                          first_s1;
	logic signed [SAMPLE_BITS-1:0] rdata_s1;
	logic signed [SAMPLE_BITS-1:0] acc_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] cand;

	logic [ROW_W-1:0] win_start;
	logic [ROW_W-1:0] win_end;
	logic [31:0]      end_raw;
	logic             wr_en;
	logic             last_issue;

	assign pop        = (state_q == ST_IDLE) && !queue_empty;
	assign wr_en      = pop;
	assign last_issue = (idx_q == end_q);

	// Window bounds of the current row, clamped to the column
	always_comb begin
		if (32'(row_q) >= 32'(radius_before)) begin
			win_start = ROW_W'(32'(row_q) - 32'(radius_before));
		end else begin
			win_start = '0;
		end
		end_raw = 32'(row_q) + 32'(radius_after);
		win_end = (end_raw > 32'(cur_q)) ? cur_q : ROW_W'(end_raw);
	end

	// Running maximum including the word just read
	assign cand = (first_s1 || (rdata_s1 > acc_q)) ? rdata_s1 : acc_q;

	// Write incoming samples and read window entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[job_row[AW-1:0]] <= job_sample;
		end
		rdata_s1 <= store_mem[idx_q[AW-1:0]];
	end

	// Accumulate and hold the finished maximum
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= cand;
		end
		if (state_q == ST_DRAIN) begin
			max_q <= cand;
		end
	end

	// Sequence rows of a job and windows of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cur_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			ending_q <= 1'b0;
			idx_q    <= '0;
			end_q    <= '0;
			first_q  <= 1'b0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			vld_s1   <= (state_q == ST_READ);
			first_s1 <= (state_q == ST_READ) && first_q;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_q    <= job_row;
						row_q    <= job_first;
						left_q   <= job_ctl.count;
						ending_q <= job_ctl.ending;
						if (job_ctl.count != '0) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					idx_q   <= win_start;
					end_q   <= win_end;
					first_q <= 1'b1;
					state_q <= ST_READ;
				end
				ST_READ: begin
					first_q <= 1'b0;
					idx_q   <= idx_q + 1'b1;
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (results.ready) begin
						if (left_q == cwmf_pkg::RUN_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							left_q  <= left_q - 1'b1;
							state_q <= ST_SETUP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Drive the result beat
	assign results.valid      = (state_q == ST_EMIT);
	assign results.window_max = max_q;
	assign results.out_row    = row_q;
	assign results.column_end = ending_q && (row_q == cur_q);
	assign results.run_last   = (left_q == cwmf_pkg::RUN_W'(1));

endmodule

// File: sv/column_window_max_filter.sv
// Top level of the column window max filter: configuration registers, front, queue and back.
// Samples of a column enter one per beat and are taken at one per cycle while the
// four-entry job queue has room; the front end only tracks row counters, so it runs ahead
// of the back end. The back end stores each sample when it takes the sample's job, and
// for each result it releases it sets up the clamped window, reads the window rows in turn
// through the single read port of the sample memory, drains the read and then holds the
// result beat until it is taken. A window covers up to radius_before + radius_after + 1
// rows. The sample memory holds the last 2*MAX_RADIUS+2 rows rounded up to a power of
// two and needs no clearing after reset.
module column_window_max_filter #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_RADIUS  = 31,
	parameter int MAX_ROWS    = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cwmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	cwmf_in_if.sink                        pixels,
	cwmf_out_if.source                     results
);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int RAD_W = $clog2(MAX_RADIUS + 1);
	localparam int AW    = $clog2(2 * MAX_RADIUS + 2);
	localparam int CTL_W = $bits(cwmf_pkg::job_ctl_t);
	localparam int JOB_W = SAMPLE_BITS + 2 * ROW_W + CTL_W;

	logic [cwmf_pkg::RADIUS_CFG_W-1:0] rb_cfg_q;
	logic [cwmf_pkg::RADIUS_CFG_W-1:0] ra_cfg_q;
	logic [cwmf_pkg::LENGTH_CFG_W-1:0] len_cfg_q;

	logic [RAD_W-1:0] radius_before;
	logic [RAD_W-1:0] radius_after;
	logic [ROW_W-1:0] last_row;
	logic [31:0]      len_ext;

	logic                          push;
	logic                          pop;
	logic                          queue_full;
	logic                          queue_empty;
	logic signed [SAMPLE_BITS-1:0] f_sample;
	logic [ROW_W-1:0]              f_row;
	logic [ROW_W-1:0]              f_first;
	cwmf_pkg::job_ctl_t            f_ctl;
	logic [JOB_W-1:0]              q_wdata;
	logic [JOB_W-1:0]              q_rdata;
	logic signed [SAMPLE_BITS-1:0] b_sample;
	logic [ROW_W-1:0]              b_row;
	logic [ROW_W-1:0]              b_first;
	cwmf_pkg::job_ctl_t            b_ctl;

	// Capture configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_cfg_q  <= cwmf_pkg::RADIUS_RESET;
			ra_cfg_q  <= cwmf_pkg::RADIUS_RESET;
			len_cfg_q <= cwmf_pkg::LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cwmf_pkg::CFG_RADIUS_BEFORE: begin
					rb_cfg_q <= cfg_wdata[cwmf_pkg::RADIUS_CFG_W-1:0];
				end
				cwmf_pkg::CFG_RADIUS_AFTER: begin
					ra_cfg_q <= cfg_wdata[cwmf_pkg::RADIUS_CFG_W-1:0];
				end
				cwmf_pkg::CFG_COLUMN_LENGTH: begin
					len_cfg_q <= cfg_wdata[cwmf_pkg::LENGTH_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Saturate radii and derive the last row of a column
	always_comb begin
		radius_before = RAD_W'(cwmf_pkg::clamp_to(32'(rb_cfg_q), 32'(MAX_RADIUS)));
		radius_after  = RAD_W'(cwmf_pkg::clamp_to(32'(ra_cfg_q), 32'(MAX_RADIUS)));
		len_ext       = cwmf_pkg::clamp_to(32'(len_cfg_q), 32'(MAX_ROWS));
		if (len_ext == 32'd0) begin
			last_row = '0;
		end else begin
			last_row = ROW_W'(len_ext - 32'd1);
		end
	end

	cwmf_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ROW_W       (ROW_W),
		.RAD_W       (RAD_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixels       (pixels),
		.radius_after (radius_after),
		.last_row     (last_row),
		.queue_full   (queue_full),
		.push         (push),
		.job_sample   (f_sample),
		.job_row      (f_row),
		.job_first    (f_first),
		.job_ctl      (f_ctl)
	);

	// Pack and unpack jobs around the queue
	assign q_wdata = {f_sample, f_row, f_first, f_ctl};
	assign {b_sample, b_row, b_first, b_ctl} = q_rdata;

	cwmf_queue #(
		.W (JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (queue_full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (queue_empty)
	);

	cwmf_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ROW_W       (ROW_W),
		.RAD_W       (RAD_W),
		.AW          (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (queue_empty),
		.pop           (pop),
		.job_sample    (b_sample),
		.job_row       (b_row),
		.job_first     (b_first),
		.job_ctl       (b_ctl),
		.radius_before (radius_before),
		.radius_after  (radius_after),
		.results       (results)
	);

endmodule
